// ===== sv/ebc_pkg.sv =====
package ebc_pkg;

    localparam int POS_W     = 17;
    localparam int CFG_W     = 16;
    localparam int M_W       = 31;
    localparam int FRAC_W    = 16;
    localparam int LOGL_W    = 21;
    localparam int RAD_W     = 32;
    localparam int REM_W     = 33;
    localparam int ROOT_W    = 31;
    localparam int QUO_W     = 33;
    localparam int EXPN_W    = 17;
    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;
    localparam int EXP_CELLS = EXP_STEPS * ROOT_W;
    localparam int LANE_DEPTH = 1 + LOG_STEPS + 1 + EXP_CELLS + 1 + 1 + LOG_STEPS + 1
                              + QUO_W + 1 + EXP_CELLS + 1;

    localparam logic [POS_W-1:0]  ONE_Q16    = 17'd65536;
    localparam logic [POS_W-1:0]  HALF_Q16   = 17'd32768;
    localparam logic [ROOT_W-1:0] EXP_SEED   = 31'h4000_0000;
    localparam logic [CFG_W-1:0]  POWER_RST  = 16'd6144;
    localparam logic [CFG_W-1:0]  GAMMA_RST  = 16'd4915;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_POWER = 1'b0;
    localparam logic CFG_IDX_GAMMA = 1'b1;

    typedef enum logic [1:0] {
        RS_CALC,
        RS_ONE,
        RS_ZERO
    } rsel_t;

    typedef struct packed {
        logic              low;
        rsel_t             rsel;
        logic [3:0]        k;
        logic [POS_W-1:0]  f;
        logic              gbyp;
        logic [EXPN_W-1:0] n;
        logic [FRAC_W-1:0] fr;
    } side_t;

    function automatic logic [3:0] top_bit(input logic [15:0] a);
        logic [3:0] k;
        k = '0;
        for (int i = 0; i < 16; i++) begin
            if (a[i]) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [M_W-1:0] norm_q30(input logic [15:0] a, input logic [3:0] k);
        return M_W'({15'b0, a} << (5'd30 - {1'b0, k}));
    endfunction

    function automatic logic [LOGL_W-1:0] neg_log(input logic [3:0] k,
                                                  input logic [FRAC_W-1:0] frac);
        return {5'd16 - {1'b0, k}, 16'b0} - {5'b0, frac};
    endfunction

    function automatic logic [POS_W-1:0] exp_final(input logic [ROOT_W-1:0] v,
                                                   input logic [EXPN_W-1:0] n);
        logic [47:0]      s;
        logic [5:0]       sh;
        logic [POS_W-1:0] r;
        sh = {1'b0, n[4:0]} + 6'd14;
        s  = {17'b0, v} + (48'd1 << (sh - 6'd1));
        r  = POS_W'(s >> sh);
        if (n > 17'd31) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== sv/ebc_log_cell.sv =====
module ebc_log_cell
    import ebc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [M_W-1:0]    m_in,
    input  logic [FRAC_W-1:0] frac_in,
    input  side_t             side_in,
    output logic [M_W-1:0]    m_out,
    output logic [FRAC_W-1:0] frac_out,
    output side_t             side_out
);

    logic [2*M_W-1:0]  sq;
    logic [M_W:0]      t;
    logic [M_W-1:0]    m_next, m_reg;
    logic [FRAC_W-1:0] frac_next, frac_reg;
    side_t             side_reg;

    // one squaring step: one fraction bit of the log
    always_comb begin
        sq = {31'b0, m_in} * {31'b0, m_in};
        t  = sq[2*M_W-1:30];
        if (t[M_W]) begin
            m_next    = t[M_W:1];
            frac_next = {frac_in[FRAC_W-2:0], 1'b1};
        end else begin
            m_next    = t[M_W-1:0];
            frac_next = {frac_in[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg    <= m_next;
            frac_reg <= frac_next;
            side_reg <= side_in;
        end
    end

    assign m_out    = m_reg;
    assign frac_out = frac_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/ebc_sqrt_cell.sv =====
module ebc_sqrt_cell
    import ebc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  side_t             side_in,
    output logic [RAD_W-1:0]  rad_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output side_t             side_out
);

    logic [REM_W+1:0]  t, trial;
    logic              ge;
    logic [RAD_W-1:0]  rad_next, rad_reg;
    logic [REM_W-1:0]  rem_next, rem_reg;
    logic [ROOT_W-1:0] root_next, root_reg;
    side_t             side_reg;

    // one root bit per cell
    always_comb begin
        t         = {rem_in, rad_in[RAD_W-1:RAD_W-2]};
        trial     = {2'b0, root_in, 2'b01};
        ge        = (t >= trial);
        rem_next  = ge ? REM_W'(t - trial) : t[REM_W-1:0];
        root_next = {root_in[ROOT_W-2:0], ge};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/ebc_div_cell.sv =====
module ebc_div_cell
    import ebc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [CFG_W-1:0] divisor,
    input  logic [QUO_W-1:0] nq_in,
    input  logic [CFG_W-1:0] rem_in,
    input  side_t            side_in,
    output logic [QUO_W-1:0] nq_out,
    output logic [CFG_W-1:0] rem_out,
    output side_t            side_out
);

    logic [CFG_W:0]   t;
    logic             ge;
    logic [QUO_W-1:0] nq_next, nq_reg;
    logic [CFG_W-1:0] rem_next, rem_reg;
    side_t            side_reg;

    // restoring step: dividend bits shift out the top, quotient bits in the bottom
    always_comb begin
        t        = {rem_in, nq_in[QUO_W-1]};
        ge       = (t >= {1'b0, divisor});
        rem_next = ge ? CFG_W'(t - {1'b0, divisor}) : t[CFG_W-1:0];
        nq_next  = {nq_in[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg   <= nq_next;
            rem_reg  <= rem_next;
            side_reg <= side_in;
        end
    end

    assign nq_out   = nq_reg;
    assign rem_out  = rem_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/ebc_exp_chain.sv =====
module ebc_exp_chain
    import ebc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  side_t             side_in,
    output logic [ROOT_W-1:0] root_out,
    output side_t             side_out
);

    logic [RAD_W-1:0]  rad_w  [0:EXP_CELLS];
    logic [REM_W-1:0]  rem_w  [0:EXP_CELLS];
    logic [ROOT_W-1:0] root_w [0:EXP_CELLS];
    side_t             side_w [0:EXP_CELLS];

    // entry of the chain holds v = 1.0 in Q30
    assign rad_w[0]  = '0;
    assign rem_w[0]  = '0;
    assign root_w[0] = EXP_SEED;
    assign side_w[0] = side_in;

    for (genvar j = 0; j < EXP_STEPS; j++) begin : g_step
        for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
            localparam int C = j * ROOT_W + i;
            logic [RAD_W-1:0]  rad_c;
            logic [REM_W-1:0]  rem_c;
            logic [ROOT_W-1:0] root_c;

            if (i == 0) begin : g_head
                logic [ROOT_W-1:0] vh;
                // halve v on a set fraction bit, then start a fresh root of v * 2^30
                assign vh     = side_w[C].fr[j] ? {1'b0, root_w[C][ROOT_W-1:1]} : root_w[C];
                assign rad_c  = {1'b0, vh};
                assign rem_c  = '0;
                assign root_c = '0;
            end else begin : g_body
                assign rad_c  = rad_w[C];
                assign rem_c  = rem_w[C];
                assign root_c = root_w[C];
            end

            ebc_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .rad_in   (rad_c),
                .rem_in   (rem_c),
                .root_in  (root_c),
                .side_in  (side_w[C]),
                .rad_out  (rad_w[C+1]),
                .rem_out  (rem_w[C+1]),
                .root_out (root_w[C+1]),
                .side_out (side_w[C+1])
            );
        end
    end

    assign root_out = root_w[EXP_CELLS];
    assign side_out = side_w[EXP_CELLS];

endmodule

// ===== sv/ebc_lane.sv =====
module ebc_lane
    import ebc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [CFG_W-1:0] ramp_power,
    input  logic [CFG_W-1:0] gamma_value,
    input  logic [POS_W-1:0] pos,
    output logic [POS_W-1:0] gain
);

    // ramp base: clamp, fold to 2x or 2(1-x), normalize for the log
    logic [POS_W-1:0] xc, bv;
    logic [3:0]       ka;
    side_t            a_side_next, a_side_reg;
    logic [M_W-1:0]   a_m_next, a_m_reg;

    always_comb begin
        xc = (pos > ONE_Q16) ? ONE_Q16 : pos;
        a_side_next     = '0;
        a_side_next.low = (xc < HALF_Q16);
        bv = a_side_next.low ? {xc[POS_W-2:0], 1'b0} : POS_W'(18'd131072 - {xc, 1'b0});
        if (ramp_power == '0 || bv[POS_W-1]) begin
            a_side_next.rsel = RS_ONE;
        end else if (bv == '0) begin
            a_side_next.rsel = RS_ZERO;
        end else begin
            a_side_next.rsel = RS_CALC;
        end
        ka            = top_bit(bv[15:0]);
        a_side_next.k = ka;
        a_m_next      = norm_q30(bv[15:0], ka);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_m_reg    <= a_m_next;
            a_side_reg <= a_side_next;
        end
    end

    // log of the base
    logic [M_W-1:0]    l1_m    [0:LOG_STEPS];
    logic [FRAC_W-1:0] l1_frac [0:LOG_STEPS];
    side_t             l1_side [0:LOG_STEPS];

    assign l1_m[0]    = a_m_reg;
    assign l1_frac[0] = '0;
    assign l1_side[0] = a_side_reg;

    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log1
        ebc_log_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .m_in     (l1_m[i]),
            .frac_in  (l1_frac[i]),
            .side_in  (l1_side[i]),
            .m_out    (l1_m[i+1]),
            .frac_out (l1_frac[i+1]),
            .side_out (l1_side[i+1])
        );
    end

    // exponent times p
    logic [LOGL_W-1:0] l1_val;
    logic [36:0]       b_prod;
    logic [24:0]       b_e;
    side_t             b_side_next, b_side_reg;

    always_comb begin
        l1_val      = neg_log(l1_side[LOG_STEPS].k, l1_frac[LOG_STEPS]);
        b_prod      = {16'b0, l1_val} * {21'b0, ramp_power};
        b_e         = 25'((b_prod + 37'd2048) >> 12);
        b_side_next    = l1_side[LOG_STEPS];
        b_side_next.n  = EXPN_W'(b_e[24:16]);
        b_side_next.fr = b_e[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= b_side_next;
        end
    end

    logic [ROOT_W-1:0] e1_root;
    side_t             e1_side;

    ebc_exp_chain u_exp1 (
        .aclk     (aclk),
        .en       (en),
        .side_in  (b_side_reg),
        .root_out (e1_root),
        .side_out (e1_side)
    );

    // power value, then the half ramp on either side of one half
    logic [POS_W-1:0] pw, half;
    side_t            c_side_next, c_side_reg;

    always_comb begin
        case (e1_side.rsel)
            RS_ONE:  pw = ONE_Q16;
            RS_ZERO: pw = '0;
            RS_CALC: pw = exp_final(e1_root, e1_side.n);
            default: pw = '0;
        endcase
        half          = POS_W'(({1'b0, pw} + 18'd1) >> 1);
        c_side_next   = e1_side;
        c_side_next.f = e1_side.low ? half : ONE_Q16 - half;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= c_side_next;
        end
    end

    // gamma setup: bypass on zero gamma or f at either end
    logic [3:0]     kd;
    side_t          d_side_next, d_side_reg;
    logic [M_W-1:0] d_m_next, d_m_reg;

    always_comb begin
        kd               = top_bit(c_side_reg.f[15:0]);
        d_side_next      = c_side_reg;
        d_side_next.k    = kd;
        d_side_next.gbyp = (gamma_value == '0) || (c_side_reg.f == '0)
                         || c_side_reg.f[POS_W-1];
        d_m_next         = norm_q30(c_side_reg.f[15:0], kd);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_m_reg    <= d_m_next;
            d_side_reg <= d_side_next;
        end
    end

    logic [M_W-1:0]    l2_m    [0:LOG_STEPS];
    logic [FRAC_W-1:0] l2_frac [0:LOG_STEPS];
    side_t             l2_side [0:LOG_STEPS];

    assign l2_m[0]    = d_m_reg;
    assign l2_frac[0] = '0;
    assign l2_side[0] = d_side_reg;

    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log2
        ebc_log_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .m_in     (l2_m[i]),
            .frac_in  (l2_frac[i]),
            .side_in  (l2_side[i]),
            .m_out    (l2_m[i+1]),
            .frac_out (l2_frac[i+1]),
            .side_out (l2_side[i+1])
        );
    end

    // dividend l * 4096 + g/2 for the rounded divide by gamma
    logic [LOGL_W-1:0] l2_val;
    logic [QUO_W-1:0]  e_nq_next, e_nq_reg;
    side_t             e_side_reg;

    always_comb begin
        l2_val    = neg_log(l2_side[LOG_STEPS].k, l2_frac[LOG_STEPS]);
        e_nq_next = QUO_W'({l2_val, 12'b0}) + QUO_W'(gamma_value[CFG_W-1:1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_nq_reg   <= e_nq_next;
            e_side_reg <= l2_side[LOG_STEPS];
        end
    end

    logic [QUO_W-1:0] dv_nq   [0:QUO_W];
    logic [CFG_W-1:0] dv_rem  [0:QUO_W];
    side_t            dv_side [0:QUO_W];

    assign dv_nq[0]   = e_nq_reg;
    assign dv_rem[0]  = '0;
    assign dv_side[0] = e_side_reg;

    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        ebc_div_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .divisor  (gamma_value),
            .nq_in    (dv_nq[i]),
            .rem_in   (dv_rem[i]),
            .side_in  (dv_side[i]),
            .nq_out   (dv_nq[i+1]),
            .rem_out  (dv_rem[i+1]),
            .side_out (dv_side[i+1])
        );
    end

    side_t f_side_next, f_side_reg;

    always_comb begin
        f_side_next    = dv_side[QUO_W];
        f_side_next.n  = dv_nq[QUO_W][QUO_W-1:FRAC_W];
        f_side_next.fr = dv_nq[QUO_W][FRAC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= f_side_next;
        end
    end

    logic [ROOT_W-1:0] e2_root;
    side_t             e2_side;

    ebc_exp_chain u_exp2 (
        .aclk     (aclk),
        .en       (en),
        .side_in  (f_side_reg),
        .root_out (e2_root),
        .side_out (e2_side)
    );

    logic [POS_W-1:0] g_gain_next, g_gain_reg;

    always_comb begin
        g_gain_next = e2_side.gbyp ? e2_side.f : exp_final(e2_root, e2_side.n);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_gain_reg <= g_gain_next;
        end
    end

    assign gain = g_gain_reg;

endmodule

// ===== sv/edge_blend_curve.sv =====
// channel   | ports                                        | role
// s_ (in)   | s_valid s_ready s_req_type s_pos_x s_pos_y   | position transfer, edge or corner
// m_ (out)  | m_valid m_ready m_blend_gain m_attenuation   | gain and attenuation transfer
// apb (cfg) | psel penable pwrite paddr pwdata prdata pready | ramp_power at 0, gamma_value at 4
//
// one transfer accepted per clock while the pipe is not stalled; most of the pipe depth lies in the
// two chains of square-root cells (16 roots of 31 bit cells each) in every lane
// synchronous active-low reset clears valid flags and loads the register defaults
// the whole pipe stalls only when its last stage and the output register are both full,
// so inputs keep flowing into bubbles while a result waits on m_ready
module edge_blend_curve
    import ebc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [POS_W-1:0] s_pos_x,
    input  logic [POS_W-1:0] s_pos_y,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_blend_gain,
    output logic [POS_W-1:0] m_attenuation,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [CFG_W-1:0] power_reg, power_next;
    logic [CFG_W-1:0] gamma_reg, gamma_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        power_next = power_reg;
        gamma_next = gamma_reg;
        if (cfg_wr) begin
            case (paddr[2])
                CFG_IDX_POWER: power_next = pwdata[CFG_W-1:0];
                CFG_IDX_GAMMA: gamma_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back, word aligned
    assign prdata = {16'b0, (paddr[2] == CFG_IDX_GAMMA) ? gamma_reg : power_reg};

    // pipe control
    logic                  en;
    logic                  out_take;
    logic [LANE_DEPTH-1:0] vld_reg, vld_next;
    logic [LANE_DEPTH-1:0] rt_reg;
    logic                  p_vld_reg, p_vld_next;
    logic                  m_valid_reg, m_valid_next;

    // output register can take a new result this cycle
    assign out_take = !m_valid_reg || m_ready;
    // pipe moves unless the corner stage holds a result that cannot drain
    assign en       = out_take || !p_vld_reg;
    assign s_ready  = en;

    always_comb begin
        vld_next     = en ? {vld_reg[LANE_DEPTH-2:0], s_valid} : vld_reg;
        p_vld_next   = en ? vld_reg[LANE_DEPTH-1] : p_vld_reg;
        m_valid_next = out_take ? p_vld_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg   <= POWER_RST;
            gamma_reg   <= GAMMA_RST;
            vld_reg     <= '0;
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            power_reg   <= power_next;
            gamma_reg   <= gamma_next;
            vld_reg     <= vld_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request type rides alongside the lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            rt_reg <= {rt_reg[LANE_DEPTH-2:0], s_req_type};
        end
    end

    // one ramp lane per position
    logic [POS_W-1:0] fx, fy;

    ebc_lane u_lane_x (
        .aclk        (aclk),
        .en          (en),
        .ramp_power  (power_reg),
        .gamma_value (gamma_reg),
        .pos         (s_pos_x),
        .gain        (fx)
    );

    ebc_lane u_lane_y (
        .aclk        (aclk),
        .en          (en),
        .ramp_power  (power_reg),
        .gamma_value (gamma_reg),
        .pos         (s_pos_y),
        .gain        (fy)
    );

    // corner product; edges go through as fx scaled to the same Q32 form
    logic [33:0] prod_reg, prod_next;

    always_comb begin
        if (rt_reg[LANE_DEPTH-1]) begin
            prod_next = 34'(fx) * 34'(fy);
        end else begin
            prod_next = 34'({fx, 16'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    // round, clamp and form the attenuation into the output register
    logic [33:0]      rsum;
    logic [POS_W-1:0] gain_next, gain_reg;
    logic [POS_W-1:0] att_next, att_reg;

    always_comb begin
        rsum      = prod_reg + 34'd32768;
        gain_next = (rsum[33:16] > {1'b0, ONE_Q16}) ? ONE_Q16 : rsum[POS_W+15:16];
        att_next  = ONE_Q16 - gain_next;
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            gain_reg <= gain_next;
            att_reg  <= att_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_blend_gain  = gain_reg;
    assign m_attenuation = att_reg;

endmodule

// ===== sv/ebc_checker.sv =====
module ebc_checker
    import ebc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [POS_W-1:0] m_blend_gain,
    input logic [POS_W-1:0] m_attenuation
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blend_gain) && $stable(m_attenuation))
        else $error("result changed while stalled");

    // gain and attenuation add to one
    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_blend_gain} + {1'b0, m_attenuation}) == 18'd65536)
        else $error("gain plus attenuation is not one");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_blend_gain <= ONE_Q16)
        else $error("gain above one");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind edge_blend_curve ebc_checker u_ebc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_blend_gain  (m_blend_gain),
    .m_attenuation (m_attenuation)
);

// ===== sim/tb_edge_blend_curve.sv =====
module tb_edge_blend_curve;
    import ebc_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_req_type = 1'b0;
    logic [POS_W-1:0] s_pos_x = '0;
    logic [POS_W-1:0] s_pos_y = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [POS_W-1:0] m_blend_gain;
    logic [POS_W-1:0] m_attenuation;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    localparam int DRAIN_CYCLES = LANE_DEPTH + 40;
    localparam logic REQ_EDGE   = 1'b0;
    localparam logic REQ_CORNER = 1'b1;

    edge_blend_curve dut (.*);

    // clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the two registers
    logic [CFG_W-1:0] shadow_power;
    logic [CFG_W-1:0] shadow_gamma;

    typedef struct {
        logic [POS_W-1:0] gain;
        logic [POS_W-1:0] atten;
    } blend_res_t;

    blend_res_t pending_gains[$];
    int         mismatch_count = 0;
    bit         inputs_done = 1'b0;

    // integer square root, bit by bit
    function automatic longint unsigned root64(input longint unsigned a);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > a) bitv >>= 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // -log2(a/65536) in q16 for a in 1..65535, by repeated squaring
    function automatic longint unsigned log_q16(input longint unsigned a);
        int              msb;
        longint unsigned mant;
        longint unsigned frac;
        msb  = 0;
        frac = 0;
        for (int i = 0; i < 16; i++) if (a[i]) msb = i;
        mant = a << (30 - msb);
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac <<= 1;
            if (mant >= (64'd1 << 31)) begin
                frac |= 1;
                mant >>= 1;
            end
        end
        return (longint'(16 - msb) << 16) - frac;
    endfunction

    // 2^-e, e in q16, via a chain of square roots
    function automatic longint unsigned pow2neg_q16(input longint unsigned e);
        longint unsigned whole;
        longint unsigned v;
        whole = e >> 16;
        v     = 64'd1 << 30;
        for (int j = 0; j < 16; j++) begin
            if (e[j]) v >>= 1;
            v = root64(v << 30);
        end
        if (whole > 31) return 0;
        return (v + (64'd1 << (whole + 13))) >> (whole + 14);
    endfunction

    function automatic longint unsigned ramp_gain(input longint unsigned x);
        bit              lower;
        longint unsigned b;
        longint unsigned pw;
        longint unsigned half;
        longint unsigned f;
        lower = x < 32768;
        b = lower ? 2 * x : 2 * (65536 - x);
        if (shadow_power == 0 || b >= 65536) pw = 65536;
        else if (b == 0) pw = 0;
        else pw = pow2neg_q16((log_q16(b) * shadow_power + 2048) >> 12);
        half = (pw + 1) >> 1;
        f = lower ? half : 65536 - half;
        if (shadow_gamma != 0 && f != 0 && f < 65536)
            f = pow2neg_q16((log_q16(f) * 4096 + (shadow_gamma >> 1)) / shadow_gamma);
        return f;
    endfunction

    function automatic blend_res_t predict_blend(input logic rt, input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py);
        longint unsigned x;
        longint unsigned y;
        longint unsigned g;
        blend_res_t      r;
        x = (px > ONE_Q16) ? 65536 : px;
        y = (py > ONE_Q16) ? 65536 : py;
        g = ramp_gain(x);
        if (rt == REQ_CORNER) g = (g * ramp_gain(y) + 32768) >> 16;
        if (g > 65536) g = 65536;
        r.gain  = POS_W'(g);
        r.atten = POS_W'(65536 - g);
        return r;
    endfunction

    // one register write: setup then access
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_IDX_POWER) shadow_power = val;
        else shadow_gamma = val;
    endtask

    // present one position transfer, wait for acceptance, queue the prediction
    // valid drops only for a gap, so back to back transfers keep it high
    task automatic send_position(input logic rt, input logic [POS_W-1:0] px,
                                 input logic [POS_W-1:0] py, input bit typed,
                                 input logic [POS_W-1:0] typed_gain);
        int         gap;
        blend_res_t exp_r;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_pos_x    <= px;
        s_pos_y    <= py;
        exp_r = predict_blend(rt, px, py);
        if (typed) begin
            exp_r.gain  = typed_gain;
            exp_r.atten = ONE_Q16 - typed_gain;
        end
        do @(posedge aclk); while (!s_ready);
        pending_gains.push_back(exp_r);
    endtask

    // wait until every queued gain has come back, then let the pipe empty
    task automatic drain_pipe;
        wait (pending_gains.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // directed rows; typed gain only where obvious
    typedef struct {
        logic             rt;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        bit               typed;
        logic [POS_W-1:0] gain;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{REQ_EDGE,   17'd0,      17'd0,      1'b1, 17'd0},
        '{REQ_EDGE,   17'd65536,  17'd0,      1'b1, 17'd65536},
        '{REQ_EDGE,   17'h1FFFF,  17'h1FFFF,  1'b1, 17'd65536},
        '{REQ_EDGE,   17'd32768,  17'h1FFFF,  1'b0, 17'd0},
        '{REQ_EDGE,   17'd32767,  17'd0,      1'b0, 17'd0},
        '{REQ_EDGE,   17'd1,      17'd0,      1'b0, 17'd0},
        '{REQ_EDGE,   17'd65535,  17'd0,      1'b0, 17'd0},
        '{REQ_EDGE,   17'd16384,  17'd5,      1'b0, 17'd0},
        '{REQ_EDGE,   17'd49152,  17'd0,      1'b0, 17'd0},
        '{REQ_CORNER, 17'd65536,  17'd65536,  1'b1, 17'd65536},
        '{REQ_CORNER, 17'd0,      17'd65536,  1'b1, 17'd0},
        '{REQ_CORNER, 17'h1FFFF,  17'd0,      1'b1, 17'd0},
        '{REQ_CORNER, 17'd32768,  17'd32768,  1'b0, 17'd0},
        '{REQ_CORNER, 17'd20000,  17'd50000,  1'b0, 17'd0},
        '{REQ_CORNER, 17'h10001,  17'd1,      1'b0, 17'd0}
    };

    task automatic random_burst(input int count);
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        for (int i = 0; i < count; i++) begin
            // mostly in range, some above one to hit the clamp
            px = ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 65536));
            py = ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 65536));
            send_position(1'($urandom), px, py, 1'b0, '0);
        end
        s_valid <= 1'b0;
    endtask

    // stimulus: directed rows, then random phases across register settings
    initial begin
        logic [CFG_W-1:0] power_set[6] = '{16'd6144, 16'd1, 16'd65535, 16'd0, 16'd4096, 16'd12288};
        logic [CFG_W-1:0] gamma_set[6] = '{16'd4915, 16'd0, 16'd65535, 16'd1, 16'd9011, 16'd2048};
        shadow_power = POWER_RST;
        shadow_gamma = GAMMA_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset defaults first
        foreach (dir_rows[i])
            send_position(dir_rows[i].rt, dir_rows[i].px, dir_rows[i].py,
                          dir_rows[i].typed, dir_rows[i].gain);
        random_burst(200);
        for (int ph = 1; ph < 6; ph++) begin
            drain_pipe();
            write_reg(CFG_IDX_POWER, power_set[ph]);
            write_reg(CFG_IDX_GAMMA, gamma_set[ph]);
            // zero power: every gain is one half before gamma
            if (ph == 3) send_position(REQ_EDGE, 17'd0, 17'd0, 1'b0, '0);
            random_burst(250);
        end
        inputs_done = 1'b1;
    end

    // result side: random stalls per transfer, field by field compare
    initial begin
        blend_res_t exp_r;
        int         stall;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_gains.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer gain=%0d atten=%0d",
                             m_blend_gain, m_attenuation);
            end else begin
                exp_r = pending_gains.pop_front();
                if (m_blend_gain !== exp_r.gain || m_attenuation !== exp_r.atten) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch gain exp %0d got %0d, atten exp %0d got %0d",
                                 exp_r.gain, m_blend_gain, exp_r.atten, m_attenuation);
                end
            end
        end
    end

    // end of run: drain, then verdict
    initial begin
        wait (inputs_done);
        drain_pipe();
        if (mismatch_count == 0 && pending_gains.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
